>>> rtl/batch_norm_channel_affine_assert.svh
// Assertion macros for the file that checks its own behavior.
`ifndef BATCH_NORM_CHANNEL_AFFINE_ASSERT_SVH
`define BATCH_NORM_CHANNEL_AFFINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BNCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BNCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bnca_pkg.sv
package bnca_pkg;

  localparam int MAX_CHANNELS_DEF = 256;
  localparam int VALUE_BITS       = 32;
  localparam int SQRT_STEPS       = 24;
  localparam int DIV_STEPS        = 49;
  localparam int RAM_WIDTH        = 99;

  typedef enum logic [1:0] {
    CFG_PLANE_SIZE    = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_EPSILON       = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic ram_rd;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic ram_we;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic mul_acc;
    logic round;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ld_ok;
    logic out_full;
  } sts_t;

endpackage

>>> rtl/bnca_ram.sv
module bnca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/bnca_ctrl.sv
module bnca_ctrl import bnca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_DINIT, ST_DIV, ST_WR,
    ST_RD, ST_M0, ST_M1, ST_M2, ST_RND, ST_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          if (in_kind) begin
            cmd.ram_rd = 1'b1;
            state_nxt  = ST_RD;
          end else if (sts.ld_ok) begin
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        cmd.ram_we = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_M0;
      end
      ST_M0: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_M1;
      end
      ST_M1: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_M2;
      end
      ST_M2: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = ST_RND;
      end
      ST_RND: begin
        cmd.round = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/bnca_dp.sv
module bnca_dp import bnca_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  input  logic [7:0]          in_param_channel,
  input  logic signed [31:0]  in_mean_value,
  input  logic [30:0]         in_variance,
  input  logic signed [31:0]  in_gamma,
  input  logic signed [31:0]  in_beta,
  input  logic signed [31:0]  in_sample,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result,
  output logic [7:0]          out_channel,
  output logic                out_saturated
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration registers.
  logic [16:0] plane_size_r;
  logic [8:0]  chan_count_r;
  logic [15:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_size_r <= 17'd1;
      chan_count_r <= 9'd1;
      eps_r        <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLANE_SIZE:    plane_size_r <= cfg_data;
        CFG_CHANNEL_COUNT: chan_count_r <= cfg_data[8:0];
        CFG_EPSILON:       eps_r        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Captured item fields.
  logic [31:0] sample_r, mean_r, beta_r, gmag_r;
  logic        gneg_r;
  logic [7:0]  ld_ch_r;
  logic [31:0] var_sum;

  assign var_sum = {1'b0, in_variance} + {16'b0, eps_r};

  // Square root, one result bit per step.
  logic [47:0] sq_n_r;
  logic [25:0] sq_rem_r;
  logic [23:0] root_r;
  logic [26:0] sq_rem2, sq_trial;

  assign sq_rem2  = {sq_rem_r[24:0], sq_n_r[47:46]};
  assign sq_trial = {1'b0, root_r, 2'b01};

  // Restoring division, one quotient bit per step.
  logic [24:0] dv_rem_r;
  logic [48:0] dv_q_r;
  logic [25:0] dv_t;

  assign dv_t = {dv_rem_r, dv_q_r[48]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      mean_r   <= in_mean_value;
      beta_r   <= in_beta;
      gneg_r   <= in_gamma[31];
      gmag_r   <= in_gamma[31] ? (32'd0 - in_gamma) : in_gamma;
      ld_ch_r  <= in_param_channel;
      sq_n_r   <= {var_sum, 16'b0};
      sq_rem_r <= '0;
      root_r   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n_r <= {sq_n_r[45:0], 2'b00};
      if (sq_rem2 >= sq_trial) begin
        sq_rem_r <= 26'(sq_rem2 - sq_trial);
        root_r   <= {root_r[22:0], 1'b1};
      end else begin
        sq_rem_r <= sq_rem2[25:0];
        root_r   <= {root_r[22:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      dv_rem_r <= '0;
      dv_q_r   <= {1'b0, gmag_r, 16'b0} + {25'b0, root_r[23:1]};
    end else if (cmd.div_step) begin
      if (dv_t >= {2'b00, root_r}) begin
        dv_rem_r <= 25'(dv_t - {2'b00, root_r});
        dv_q_r   <= {dv_q_r[47:0], 1'b1};
      end else begin
        dv_rem_r <= dv_t[24:0];
        dv_q_r   <= {dv_q_r[47:0], 1'b0};
      end
    end
  end

  // Factor saturation at write time.
  logic [32:0] fmag;
  logic        fclip, q_over_pos, q_over_neg;

  assign q_over_pos = |dv_q_r[48:32];
  assign q_over_neg = (|dv_q_r[48:33]) | (dv_q_r[32] & (|dv_q_r[31:0]));

  always_comb begin
    fmag  = dv_q_r[32:0];
    fclip = 1'b0;
    if (root_r == '0) begin
      fmag  = gneg_r ? {1'b1, 32'b0} : {1'b0, 32'hFFFF_FFFF};
      fclip = 1'b1;
    end else if (gneg_r && q_over_neg) begin
      fmag  = {1'b1, 32'b0};
      fclip = 1'b1;
    end else if (!gneg_r && q_over_pos) begin
      fmag  = {1'b0, 32'hFFFF_FFFF};
      fclip = 1'b1;
    end
  end

  // Channel parameter memory: mean, factor sign and magnitude, clip, beta.
  logic [RAM_WIDTH-1:0] rd_data;
  logic [7:0]           ch_r;

  bnca_ram #(.WIDTH(RAM_WIDTH), .DEPTH(MAX_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (AW'(ld_ch_r)),
    .wdata ({mean_r, gneg_r, fmag, fclip, beta_r}),
    .re    (cmd.ram_rd),
    .raddr (AW'(ch_r)),
    .rdata (rd_data)
  );

  logic [31:0] rd_mean, rd_beta;
  logic [32:0] rd_fmag;
  logic        rd_fneg, rd_clip;

  assign rd_mean = rd_data[98:67];
  assign rd_fneg = rd_data[66];
  assign rd_fmag = rd_data[65:33];
  assign rd_clip = rd_data[32];
  assign rd_beta = rd_data[31:0];

  assign sts.ld_ok    = ({24'b0, in_param_channel} < 32'(MAX_CHANNELS));
  assign sts.out_full = out_valid & out_stall;

  // Sample path.
  logic [32:0] diff, md_r;
  logic        neg_r;
  logic [49:0] prod_r;
  logic [65:0] acc_r;
  logic [50:0] rnd_r;
  logic [66:0] acc_rnd;
  logic [52:0] sval, vsum;
  logic        sat_hi, sat_lo;
  logic [31:0] res;

  assign diff    = {sample_r[31], sample_r} - {rd_mean[31], rd_mean};
  assign acc_rnd = {1'b0, acc_r} + 67'h8000;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      md_r  <= diff[32] ? (33'd0 - diff) : diff;
      neg_r <= diff[32] ^ (rd_fneg & (rd_fmag != '0));
    end
    if (cmd.mul_lo) begin
      prod_r <= {33'b0, rd_fmag[16:0]} * {17'b0, md_r};
    end else if (cmd.mul_hi) begin
      acc_r  <= {16'b0, prod_r};
      prod_r <= {34'b0, rd_fmag[32:17]} * {17'b0, md_r};
    end else if (cmd.mul_acc) begin
      acc_r <= acc_r + {prod_r[48:0], 17'b0};
    end
    if (cmd.round) begin
      rnd_r <= acc_rnd[66:16];
    end
  end

  assign sval   = neg_r ? (53'd0 - {2'b00, rnd_r}) : {2'b00, rnd_r};
  assign vsum   = sval + {{21{rd_beta[31]}}, rd_beta};
  assign sat_hi = !vsum[52] && (|vsum[51:31]);
  assign sat_lo = vsum[52] && !(&vsum[51:31]);
  assign res    = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : vsum[31:0]);

  // Plane and channel counters.
  logic [15:0] pos_r;
  logic [16:0] plim;
  logic [31:0] clim;
  logic [8:0]  cc;

  always_comb begin
    plim = plane_size_r;
    if (plim == '0) begin
      plim = 17'd1;
    end else if (plim > 17'd65536) begin
      plim = 17'd65536;
    end
    cc = chan_count_r;
    if (cc == '0) begin
      cc = 9'd1;
    end else if (cc > 9'd256) begin
      cc = 9'd256;
    end
    clim = {23'b0, cc};
    if (clim > 32'(MAX_CHANNELS)) begin
      clim = 32'(MAX_CHANNELS);
    end
  end

  logic        out_valid_r;
  logic [31:0] out_result_r;
  logic [7:0]  out_channel_r;
  logic        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (({1'b0, pos_r} + 17'd1) >= plim) begin
          pos_r <= '0;
          ch_r  <= (({24'b0, ch_r} + 32'd1) >= clim) ? 8'd0 : ch_r + 8'd1;
        end else begin
          pos_r <= pos_r + 16'd1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_r  <= res;
      out_channel_r <= ch_r;
      out_sat_r     <= rd_clip | sat_hi | sat_lo;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_channel   = out_channel_r;
  assign out_saturated = out_sat_r;

endmodule

>>> rtl/batch_norm_channel_affine.sv
// Per-channel batch normalization for inference on signed Q16.16 words. A load word
// (kind 0) stores one channel's mean and beta together with gamma / sqrt(variance +
// epsilon), rounded and clipped to 33 bits; it keeps the block busy through a
// bit-serial square root (24 steps) followed by a bit-serial divider (49 steps).
// Loads to a channel at or beyond MAX_CHANNELS are dropped. A sample word (kind 1)
// passes through a memory read, a subtract, a 33x17 and a 33x16 partial product,
// their sum, rounding and the final offset and clip. Samples are taken in
// channel-major plane order; the plane and channel counters advance as each result
// is loaded into the output register, and wrap at the configured plane size and
// channel count. The output register lets a new word be accepted while the previous
// result still waits. There is no clearing pass: a channel must be loaded before its
// samples arrive.
module batch_norm_channel_affine import bnca_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_param_channel,
  input  logic signed [31:0] in_mean_value,
  input  logic [30:0]        in_variance,
  input  logic signed [31:0] in_gamma,
  input  logic signed [31:0] in_beta,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result,
  output logic [7:0]         out_channel,
  output logic               out_saturated
);

`include "batch_norm_channel_affine_assert.svh"

  cmd_t cmd;
  sts_t sts;

  // The controller sequences loads and samples; it never touches the data.
  bnca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds configuration, the channel memory, the arithmetic and the
  // output register.
  bnca_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_param_channel (in_param_channel),
    .in_mean_value    (in_mean_value),
    .in_variance      (in_variance),
    .in_gamma         (in_gamma),
    .in_beta          (in_beta),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result       (out_result),
    .out_channel      (out_channel),
    .out_saturated    (out_saturated)
  );

  // An accepted sample word always keeps the block busy in the next cycle.
  `BNCA_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && in_kind, in_stall, "sample not held")
  // A new result only appears after the block has been working on a word.
  `BNCA_ASSERT_SAME(a_result_src, $rose(out_valid), $past(in_stall), "result without work")

endmodule

>>> bench/batch_norm_channel_affine_checker.sv
module batch_norm_channel_affine_checker import bnca_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_param_channel,
  input  logic signed [31:0] in_mean_value,
  input  logic [30:0]        in_variance,
  input  logic signed [31:0] in_gamma,
  input  logic signed [31:0] in_beta,
  input  logic signed [31:0] in_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result,
  input  logic [7:0]         out_channel,
  input  logic               out_saturated,
  input  logic               end_of_test,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] result;
    logic [7:0]         channel;
    logic               saturated;
  } norm_word_t;

  norm_word_t pending_norms[$];

  logic [16:0] plane_reg;
  logic [8:0]  chans_reg;
  logic [15:0] eps_reg;
  longint      mean_tab[256];
  longint      factor_tab[256];
  bit          factor_clip_tab[256];
  longint      offset_tab[256];
  int unsigned plane_pos;
  int unsigned cur_chan;
  bit          leftovers_reported;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic longint unsigned int_root(input longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // A load word folds gamma and the variance into one rounded, clipped factor.
  task automatic store_channel();
    longint          g;
    longint unsigned s, r, mag, q, lim;
    bit              clip;
    g = longint'(in_gamma);
    s = longint'(in_variance) + longint'(eps_reg);
    r = int_root(s << 16);
    lim = 64'd1 << 32;
    clip = 0;
    if (r == 0) begin
      factor_tab[in_param_channel] = (g >= 0) ? longint'(lim - 1) : -longint'(lim);
      clip = 1;
    end else begin
      mag = (g < 0) ? longint'(-g) : longint'(g);
      q = ((mag << 16) + (r >> 1)) / r;
      if (g < 0) begin
        if (q > lim) begin
          q = lim;
          clip = 1;
        end
        factor_tab[in_param_channel] = -longint'(q);
      end else begin
        if (q > lim - 1) begin
          q = lim - 1;
          clip = 1;
        end
        factor_tab[in_param_channel] = longint'(q);
      end
    end
    factor_clip_tab[in_param_channel] = clip;
    mean_tab[in_param_channel] = longint'(in_mean_value);
    offset_tab[in_param_channel] = longint'(in_beta);
  endtask

  // A sample word yields (sample - mean) * factor + beta for the current channel.
  task automatic predict_norm();
    longint          diff, fac, val, plim, clim;
    longint unsigned md, mf, shifted;
    logic [127:0]    prod;
    bit              neg, clip;
    norm_word_t      w;
    diff = longint'(in_sample) - mean_tab[cur_chan];
    fac = factor_tab[cur_chan];
    md = (diff < 0) ? longint'(-diff) : longint'(diff);
    mf = (fac < 0) ? longint'(-fac) : longint'(fac);
    neg = (diff < 0) != (fac < 0);
    prod = {64'd0, md} * {64'd0, mf};
    prod = prod + 128'h8000;
    shifted = (prod[127:64] >= (64'd1 << 14)) ? (64'd1 << 62) : prod[79:16];
    val = neg ? -longint'(shifted) : longint'(shifted);
    val += offset_tab[cur_chan];
    clip = factor_clip_tab[cur_chan];
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
      clip = 1;
    end
    if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
      clip = 1;
    end
    w.result = val[31:0];
    w.channel = cur_chan[7:0];
    w.saturated = clip;
    pending_norms.push_back(w);

    plim = (plane_reg == 0) ? 1 : ((plane_reg > 65536) ? 65536 : plane_reg);
    clim = (chans_reg == 0) ? 1 : ((chans_reg > 256) ? 256 : chans_reg);
    if (plane_pos + 1 >= plim) begin
      plane_pos = 0;
      cur_chan = (cur_chan + 1 >= clim) ? 0 : cur_chan + 1;
    end else begin
      plane_pos = (plane_pos + 1) & 16'hFFFF;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      plane_reg <= 17'd1;
      chans_reg <= 9'd1;
      eps_reg <= 16'd1;
      plane_pos = 0;
      cur_chan = 0;
      leftovers_reported = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_norms.size() == 0) begin
          report_mismatch($sformatf("unexpected word result=%h", out_result));
        end else begin
          norm_word_t w;
          w = pending_norms.pop_front();
          if (out_result !== w.result)
            report_mismatch($sformatf("result %h, want %h", out_result, w.result));
          if (out_channel !== w.channel)
            report_mismatch($sformatf("channel %0d, want %0d", out_channel, w.channel));
          if (out_saturated !== w.saturated)
            report_mismatch($sformatf("saturated %b, want %b", out_saturated, w.saturated));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind) predict_norm();
        else store_channel();
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PLANE_SIZE:    plane_reg <= cfg_data;
          CFG_CHANNEL_COUNT: chans_reg <= cfg_data[8:0];
          CFG_EPSILON:       eps_reg <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (end_of_test && !leftovers_reported && pending_norms.size() != 0) begin
        leftovers_reported = 1;
        report_mismatch($sformatf("%0d words never arrived", pending_norms.size()));
      end
    end
  end

endmodule

>>> bench/batch_norm_channel_affine_tb.sv
module batch_norm_channel_affine_tb;
  import bnca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [16:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [7:0]         in_param_channel;
  logic signed [31:0] in_mean_value;
  logic [30:0]        in_variance;
  logic signed [31:0] in_gamma;
  logic signed [31:0] in_beta;
  logic signed [31:0] in_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result;
  logic [7:0]         out_channel;
  logic               out_saturated;
  logic               end_of_test;
  int                 fail_count;

  // Samples accepted by the block and results taken from it; the two match
  // whenever the block holds no sample word in flight.
  int samples_sent;
  int results_seen;
  bit pressure_done;

  batch_norm_channel_affine DUT (.*);

  batch_norm_channel_affine_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Mostly back-to-back words, some short gaps and the odd long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word and hold it steady until the block takes it, then idle
  // for a random gap. Called right after a rising edge.
  task automatic send_word(input bit kind, input logic [7:0] chan,
                           input logic [31:0] mean_v, input logic [30:0] var_v,
                           input logic [31:0] gamma_v, input logic [31:0] beta_v,
                           input logic [31:0] sample_v);
    int gap;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_param_channel <= chan;
    in_mean_value <= mean_v;
    in_variance <= var_v;
    in_gamma <= gamma_v;
    in_beta <= beta_v;
    in_sample <= sample_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind) samples_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Variance leans toward zero and tiny values, so that the zero divisor and a
  // clipped factor both come up, especially while epsilon is zero.
  task automatic load_random(input logic [7:0] chan);
    logic [30:0] var_v;
    logic [31:0] mean_v, gamma_v;
    case ($urandom_range(0, 4))
      0: var_v = 31'd0;
      1: var_v = 31'($urandom_range(1, 255));
      2: var_v = 31'h7FFFFFFF;
      default: var_v = 31'($urandom());
    endcase
    mean_v = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    gamma_v = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    send_word(1'b0, chan, mean_v, var_v, gamma_v, $urandom(), $urandom());
  endtask

  task automatic sample_random();
    logic [31:0] sample_v;
    sample_v = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    send_word(1'b1, 8'($urandom()), $urandom(), 31'($urandom()), $urandom(), $urandom(),
              sample_v);
  endtask

  // Let every expected result drain, then allow for a load still grinding
  // through its square root and divide before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen != samples_sent) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One phase: new settings, then samples mixed with reloads of low channels
  // (the current channel is often among them). All channels are loaded by
  // the time this runs, so no sample reads an unwritten entry.
  task automatic run_phase(input logic [16:0] plane, input logic [16:0] chans,
                           input logic [16:0] eps, input int count);
    settle();
    write_cfg(CFG_PLANE_SIZE, plane);
    write_cfg(CFG_CHANNEL_COUNT, chans);
    write_cfg(CFG_EPSILON, eps);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) load_random(8'($urandom_range(0, 3)));
      else sample_random();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // streaming, so the output register and then the input side back up.
  initial begin
    int gap;
    out_stall = 1'b0;
    pressure_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && samples_sent > 150) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        pressure_done = 1;
      end else begin
        gap = pick_gap();
        out_stall <= (gap > 0);
        repeat ((gap > 0) ? gap : 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) results_seen++;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PLANE_SIZE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_param_channel = '0;
    in_mean_value = '0;
    in_variance = '0;
    in_gamma = '0;
    in_beta = '0;
    in_sample = '0;
    end_of_test = 1'b0;
    samples_sent = 0;
    results_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings: one plane, one channel, epsilon of
    // one lsb. Field extremes, a zero gamma and a factor that clips.
    send_word(1'b0, 8'd0, 32'd0, 31'd0, 32'h00010000, 32'd0, 32'd0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'd0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h7FFFFFFF);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h80000000);
    send_word(1'b0, 8'd0, 32'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 32'h80000000, 0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h80000000);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h7FFFFFFF);
    send_word(1'b0, 8'd0, 32'h80000000, 31'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h7FFFFFFF);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'hFFFFFFFF);
    send_word(1'b0, 8'd0, 32'h00018000, 31'h00040000, 32'd0, 32'hFFFF0000, 0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h00020000);
    send_word(1'b0, 8'd0, 32'hFFFF8000, 31'h00010000, 32'hFFFE8000, 32'h00008000, 0);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'h00000001);
    send_word(1'b1, 8'd0, 0, 0, 0, 0, 32'hFFFF0000);
    // A load to the top channel, out of the current counting range.
    send_word(1'b0, 8'hFF, 32'h12345678, 31'h00001000, 32'h00020000, 32'h55555555, 0);

    // Fill every channel, then stream samples from channel 0 upward.
    settle();
    write_cfg(CFG_PLANE_SIZE, 17'd3);
    write_cfg(CFG_CHANNEL_COUNT, 17'd256);
    write_cfg(CFG_EPSILON, 17'($urandom_range(0, 65535)));
    for (int c = 0; c < 256; c++) load_random(c[7:0]);
    for (int i = 0; i < 40; i++) sample_random();

    // Zero plane size and channel count act as one; epsilon zero exposes
    // the zero divisor.
    run_phase(17'd0, 17'd0, 17'd0, 40);
    run_phase(17'h1FFFF, 17'd511, 17'd65535, 30);
    run_phase(17'd65536, 17'd256, 17'd12, 20);
    run_phase(17'd1, 17'd7, 17'd0, 40);
    run_phase(17'd2, 17'd256, 17'($urandom_range(0, 65535)), 50);
    run_phase(17'd5, 17'd3, 17'd1, 40);

    settle();
    end_of_test <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
